@@ sv/tfdp_pkg.sv @@
`default_nettype none

package tfdp_pkg;

  localparam logic [7:0] MARK_START = 8'h73;
  localparam logic [7:0] MARK_COMMA = 8'h2C;
  localparam logic [7:0] MARK_SLASH = 8'h2F;
  localparam logic [7:0] MARK_END   = 8'h65;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [15:0] MAG_CAP = 16'h8000;
  localparam logic [15:0] POS_MAX = 16'h7FFF;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_THIRD  = 2'd3;

  localparam logic [1:0] ST_BLANK  = 2'd0;
  localparam logic [1:0] ST_SIGN   = 2'd1;
  localparam logic [1:0] ST_DIGITS = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  typedef struct packed {
    logic               fire;
    logic signed [15:0] first_length;
    logic signed [15:0] second_length;
    logic signed [15:0] third_length;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } item_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [15:0] field_value(input logic neg, input logic [15:0] mag);
    logic [16:0] m;
    m = {1'b0, mag};
    if (neg) begin
      if (mag > MAG_CAP) begin
        m = {1'b0, MAG_CAP};
      end
      return 16'((17'h10000 - m) & 17'h0FFFF);
    end
    if (mag > POS_MAX) begin
      return POS_MAX;
    end
    return mag;
  endfunction

endpackage

`default_nettype wire

@@ sv/tfdp_in_stage.sv @@
`default_nettype none

module tfdp_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            advance,
  output tfdp_pkg::item_t      item
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

`default_nettype wire

@@ sv/tfdp_parser.sv @@
`default_nettype none

module tfdp_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  output tfdp_pkg::result_t     res
);

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  stage_r, stage_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] mag_r, mag_nxt;
  logic [15:0] first_r, first_nxt;
  logic [15:0] second_r, second_nxt;
  logic [15:0] cur;
  logic [18:0] acc;
  logic        digit;
  logic        take;

  assign cur   = tfdp_pkg::field_value(neg_r, mag_r);
  assign digit = tfdp_pkg::is_digit(rx_byte);
  assign acc   = {mag_r, 3'b000} + {2'b00, mag_r, 1'b0}
               + {15'd0, 4'(rx_byte - tfdp_pkg::CH_ZERO)};

  always_comb begin
    phase_nxt  = phase_r;
    stage_nxt  = stage_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    take       = 1'b0;
    res        = '0;
    if (rx_byte == tfdp_pkg::MARK_START) begin
      phase_nxt  = tfdp_pkg::PH_FIRST;
      first_nxt  = '0;
      second_nxt = '0;
      stage_nxt  = tfdp_pkg::ST_BLANK;
      neg_nxt    = 1'b0;
      mag_nxt    = '0;
    end else if (phase_r != tfdp_pkg::PH_IDLE) begin
      if (rx_byte == tfdp_pkg::MARK_COMMA) begin
        if (phase_r == tfdp_pkg::PH_FIRST) begin
          first_nxt = cur;
        end
        second_nxt = '0;
        phase_nxt  = tfdp_pkg::PH_SECOND;
        stage_nxt  = tfdp_pkg::ST_BLANK;
        neg_nxt    = 1'b0;
        mag_nxt    = '0;
      end else if (rx_byte == tfdp_pkg::MARK_SLASH) begin
        if (phase_r == tfdp_pkg::PH_FIRST) begin
          first_nxt  = cur;
          second_nxt = '0;
        end else if (phase_r == tfdp_pkg::PH_SECOND) begin
          second_nxt = cur;
        end
        phase_nxt = tfdp_pkg::PH_THIRD;
        stage_nxt = tfdp_pkg::ST_BLANK;
        neg_nxt   = 1'b0;
        mag_nxt   = '0;
      end else if (rx_byte == tfdp_pkg::MARK_END) begin
        res.fire          = 1'b1;
        res.first_length  = first_r;
        res.second_length = second_r;
        res.third_length  = '0;
        case (phase_r)
          tfdp_pkg::PH_FIRST: begin
            res.first_length  = cur;
            res.second_length = '0;
          end
          tfdp_pkg::PH_SECOND: begin
            res.second_length = cur;
          end
          default: begin
            res.third_length = cur;
          end
        endcase
        phase_nxt = tfdp_pkg::PH_IDLE;
        stage_nxt = tfdp_pkg::ST_BLANK;
        neg_nxt   = 1'b0;
        mag_nxt   = '0;
      end else begin
        case (stage_r)
          tfdp_pkg::ST_BLANK: begin
            if (tfdp_pkg::is_blank(rx_byte)) begin
              stage_nxt = stage_r;
            end else if (rx_byte == tfdp_pkg::CH_PLUS || rx_byte == tfdp_pkg::CH_MINUS) begin
              neg_nxt   = (rx_byte == tfdp_pkg::CH_MINUS);
              stage_nxt = tfdp_pkg::ST_SIGN;
            end else if (digit) begin
              take = 1'b1;
            end else begin
              stage_nxt = tfdp_pkg::ST_DONE;
            end
          end
          tfdp_pkg::ST_SIGN, tfdp_pkg::ST_DIGITS: begin
            if (digit) begin
              take = 1'b1;
            end else begin
              stage_nxt = tfdp_pkg::ST_DONE;
            end
          end
          default: begin
            stage_nxt = stage_r;
          end
        endcase
        if (take) begin
          mag_nxt   = (acc > {3'b000, tfdp_pkg::MAG_CAP}) ? tfdp_pkg::MAG_CAP : acc[15:0];
          stage_nxt = tfdp_pkg::ST_DIGITS;
        end
      end
    end
    if (!step) begin
      res.fire = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tfdp_pkg::PH_IDLE;
      stage_r  <= tfdp_pkg::ST_BLANK;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      stage_r  <= stage_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/three_field_decimal_frame_parser.sv @@
`default_nettype none

// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_rx_byte
// out      output     out_valid, out_ready, out_first_length, out_second_length,
//                     out_third_length
//
// One byte is accepted per cycle unless the output stalls; a result is registered once its 'e' byte is parsed.
// A byte passes an input register, one parse step and the result register.
// Synchronous active-low reset returns the parser to waiting for a start mark.
// A stalled result stalls the pipeline; input is still taken while a slot is free.

module three_field_decimal_frame_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_first_length,
  output logic signed [15:0]      out_second_length,
  output logic signed [15:0]      out_third_length
);

  tfdp_pkg::item_t   item;
  tfdp_pkg::result_t res;
  logic              advance;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic signed [15:0] first_r;
  logic signed [15:0] second_r;
  logic signed [15:0] third_r;

  assign advance = !out_valid_r || out_ready;

  tfdp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .item       (item)
  );

  tfdp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance && item.valid),
    .rx_byte (item.rx_byte),
    .res     (res)
  );

  assign out_valid_nxt = advance ? res.fire : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.fire) begin
      first_r  <= res.first_length;
      second_r <= res.second_length;
      third_r  <= res.third_length;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_length  = first_r;
  assign out_second_length = second_r;
  assign out_third_length  = third_r;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] first_length;
    logic signed [15:0] second_length;
    logic signed [15:0] third_length;
  } frame_values_t;

  class frame_predictor;
    logic [1:0]    phase;
    logic [1:0]    stage;
    logic          neg;
    logic [15:0]   mag;
    logic [15:0]   first_v;
    logic [15:0]   second_v;
    frame_values_t expected_frames[$];
    int            mismatches;
    int            bytes_taken;

    function new();
      phase = tfdp_pkg::PH_IDLE;
      clear_number();
      first_v = '0;
      second_v = '0;
      mismatches = 0;
      bytes_taken = 0;
    endfunction

    function void clear_number();
      stage = tfdp_pkg::ST_BLANK;
      neg = 1'b0;
      mag = '0;
    endfunction

    function logic [15:0] signed_value();
      if (neg) begin
        return 16'h0 - ((mag > tfdp_pkg::MAG_CAP) ? tfdp_pkg::MAG_CAP : mag);
      end
      return (mag > tfdp_pkg::POS_MAX) ? tfdp_pkg::POS_MAX : mag;
    endfunction

    function void take_digit(logic [7:0] c);
      logic        digit;
      logic [31:0] m;
      digit = (c >= tfdp_pkg::CH_ZERO) && (c <= tfdp_pkg::CH_NINE);
      case (stage)
        tfdp_pkg::ST_BLANK: begin
          if ((c == tfdp_pkg::CH_SPACE) ||
              ((c >= tfdp_pkg::CH_TAB) && (c <= tfdp_pkg::CH_CR))) begin
            return;
          end
          if ((c == tfdp_pkg::CH_PLUS) || (c == tfdp_pkg::CH_MINUS)) begin
            neg = (c == tfdp_pkg::CH_MINUS);
            stage = tfdp_pkg::ST_SIGN;
            return;
          end
          if (!digit) begin
            stage = tfdp_pkg::ST_DONE;
            return;
          end
        end
        tfdp_pkg::ST_SIGN, tfdp_pkg::ST_DIGITS: begin
          if (!digit) begin
            stage = tfdp_pkg::ST_DONE;
            return;
          end
        end
        default: begin
          return;
        end
      endcase
      m = mag * 32'd10 + c - tfdp_pkg::CH_ZERO;
      if (m > 32'(tfdp_pkg::MAG_CAP)) begin
        m = 32'(tfdp_pkg::MAG_CAP);
      end
      mag = m[15:0];
      stage = tfdp_pkg::ST_DIGITS;
    endfunction

    function void take_byte(logic [7:0] c);
      frame_values_t f;
      bytes_taken++;
      if (c == tfdp_pkg::MARK_START) begin
        phase = tfdp_pkg::PH_FIRST;
        first_v = '0;
        second_v = '0;
        clear_number();
      end else if (phase != tfdp_pkg::PH_IDLE) begin
        case (c)
          tfdp_pkg::MARK_COMMA: begin
            if (phase == tfdp_pkg::PH_FIRST) begin
              first_v = signed_value();
            end
            second_v = '0;
            phase = tfdp_pkg::PH_SECOND;
            clear_number();
          end
          tfdp_pkg::MARK_SLASH: begin
            if (phase == tfdp_pkg::PH_FIRST) begin
              first_v = signed_value();
              second_v = '0;
            end else if (phase == tfdp_pkg::PH_SECOND) begin
              second_v = signed_value();
            end
            phase = tfdp_pkg::PH_THIRD;
            clear_number();
          end
          tfdp_pkg::MARK_END: begin
            f.first_length = first_v;
            f.second_length = second_v;
            f.third_length = '0;
            case (phase)
              tfdp_pkg::PH_FIRST: begin
                f.first_length = signed_value();
                f.second_length = '0;
              end
              tfdp_pkg::PH_SECOND: begin
                f.second_length = signed_value();
              end
              default: begin
                f.third_length = signed_value();
              end
            endcase
            expected_frames.push_back(f);
            phase = tfdp_pkg::PH_IDLE;
            clear_number();
          end
          default: begin
            take_digit(c);
          end
        endcase
      end
    endfunction

    task flag(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task compare_field(string name, logic signed [15:0] got, logic signed [15:0] want);
      if (got !== want) begin
        flag($sformatf("%s got %0d, want %0d", name, got, want));
      end
    endtask

    task check_frame(logic signed [15:0] a, logic signed [15:0] b, logic signed [15:0] d);
      frame_values_t f;
      if (expected_frames.size() == 0) begin
        flag($sformatf("result %0d/%0d/%0d with no frame pending", a, b, d));
      end else begin
        f = expected_frames.pop_front();
        compare_field("first_length", a, f.first_length);
        compare_field("second_length", b, f.second_length);
        compare_field("third_length", d, f.third_length);
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_first_length;
  logic signed [15:0] out_second_length;
  logic signed [15:0] out_third_length;

  frame_predictor sb;
  logic [7:0]     frame_bytes[$];
  bit             steady = 1'b0;
  bit             squeezed = 1'b0;

  three_field_decimal_frame_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_first_length (out_first_length),
    .out_second_length(out_second_length),
    .out_third_length (out_third_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Each accepted transaction is seen here, results before inputs.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_frame(out_first_length, out_second_length, out_third_length);
      end
      if (in_valid && in_ready) begin
        sb.take_byte(in_rx_byte);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!squeezed && (sb.bytes_taken >= 500)) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      out_ready <= steady || ($urandom_range(99, 0) >= 15);
    end
  end

  task send_byte(logic [7:0] b);
    while (!steady && ($urandom_range(99, 0) < 15)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task send_queued();
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      frame_bytes.push_back(s[i]);
    end
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255, 0));
    end while ((b == tfdp_pkg::MARK_START) || (b == tfdp_pkg::MARK_COMMA) ||
               (b == tfdp_pkg::MARK_SLASH) || (b == tfdp_pkg::MARK_END));
    return b;
  endfunction

  function automatic void push_field();
    int kind;
    int n;
    int r;
    kind = $urandom_range(99, 0);
    repeat ($urandom_range(2, 0)) begin
      r = $urandom_range(6, 0);
      frame_bytes.push_back((r < 5) ? 8'(tfdp_pkg::CH_TAB + r) : tfdp_pkg::CH_SPACE);
    end
    if (kind < 12) begin
      case ($urandom_range(5, 0))
        0: push_text("32767");
        1: push_text("32768");
        2: push_text("99999");
        3: push_text("-32768");
        4: push_text("-32769");
        default: push_text("+0");
      endcase
    end else begin
      case ($urandom_range(2, 0))
        1: frame_bytes.push_back(tfdp_pkg::CH_PLUS);
        2: frame_bytes.push_back(tfdp_pkg::CH_MINUS);
        default: ;
      endcase
      n = (kind < 20) ? 0 : (kind < 30) ? $urandom_range(8, 6) : $urandom_range(5, 1);
      repeat (n) frame_bytes.push_back(8'(tfdp_pkg::CH_ZERO + $urandom_range(9, 0)));
    end
    if ($urandom_range(4, 0) == 0) begin
      repeat ($urandom_range(3, 1)) frame_bytes.push_back(junk_byte());
    end
  endfunction

  function automatic void push_mark(logic [7:0] c);
    frame_bytes.push_back(c);
    push_field();
  endfunction

  function automatic void push_frame();
    int shape;
    shape = $urandom_range(99, 0);
    push_mark(tfdp_pkg::MARK_START);
    if (shape < 68) begin
      push_mark(tfdp_pkg::MARK_COMMA);
      push_mark(tfdp_pkg::MARK_SLASH);
    end else if (shape < 74) begin
      push_mark(tfdp_pkg::MARK_COMMA);
      push_mark(tfdp_pkg::MARK_COMMA);
      push_mark(tfdp_pkg::MARK_SLASH);
    end else if (shape < 78) begin
      push_mark(tfdp_pkg::MARK_COMMA);
      push_mark(tfdp_pkg::MARK_SLASH);
      push_mark(tfdp_pkg::MARK_COMMA);
    end else if (shape < 84) begin
      push_mark(tfdp_pkg::MARK_SLASH);
    end else if (shape < 88) begin
      push_mark(tfdp_pkg::MARK_COMMA);
      push_mark(tfdp_pkg::MARK_SLASH);
      push_mark(tfdp_pkg::MARK_SLASH);
    end else if (shape < 93) begin
      if (shape[0]) begin
        push_mark(tfdp_pkg::MARK_COMMA);
      end
    end else if (shape < 97) begin
      push_mark(tfdp_pkg::MARK_COMMA);
      push_mark(tfdp_pkg::MARK_START);
      push_mark(tfdp_pkg::MARK_COMMA);
      push_mark(tfdp_pkg::MARK_SLASH);
    end else begin
      push_mark(tfdp_pkg::MARK_COMMA);
      return;
    end
    frame_bytes.push_back(tfdp_pkg::MARK_END);
  endfunction

  initial begin
    int frame_count;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(tfdp_pkg::MARK_END);
    send_text("s\t+12,,-7/3/x9e");
    send_text("s99999/-99999e");

    frame_count = 0;
    while (frame_count < 1200) begin
      steady = (frame_count >= 700) && (frame_count < 900);
      frame_bytes.delete();
      if ($urandom_range(99, 0) < 20) begin
        repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom_range(255, 0)));
      end else begin
        push_frame();
        frame_count += frame_bytes.size();
      end
      send_queued();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
